/* src/trm_pkg.sv */
package trm_pkg;

    localparam int RUN_DEPTH = 32;
    localparam int IDX_W     = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
    localparam int CNT_W     = $clog2(RUN_DEPTH + 1);
    localparam int KEY_W     = 64;
    localparam int CMD_W     = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MERGE         = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
    } in_t;

    typedef struct packed {
        logic [KEY_W-1:0] out_key;
        logic             last;
    } out_t;

    typedef struct packed {
        logic append_first;
        logic append_second;
        logic step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic runs_empty;
        logic out_free;
        logic step_last;
    } dp_status_t;

endpackage

/* src/trm_ctrl.sv */
module trm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                key_valid,
    output logic                key_stall,
    input  logic [1:0]          cmd,
    input  trm_pkg::dp_status_t status,
    output trm_pkg::dp_cmd_t    ctl
);

    trm_pkg::state_t state_reg;
    trm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        key_stall         = 1'b1;
        ctl.append_first  = 1'b0;
        ctl.append_second = 1'b0;
        ctl.step          = 1'b0;
        ctl.finish        = 1'b0;
        case (state_reg)
            trm_pkg::ST_IDLE:
            begin
                key_stall = 1'b0;
                if (key_valid)
                begin
                    case (cmd)
                        trm_pkg::CMD_APPEND_FIRST:  ctl.append_first  = 1'b1;
                        trm_pkg::CMD_APPEND_SECOND: ctl.append_second = 1'b1;
                        trm_pkg::CMD_MERGE:
                        begin
                            if (!status.runs_empty)
                            begin
                                state_next = trm_pkg::ST_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            trm_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    ctl.step = 1'b1;
                    if (status.step_last)
                    begin
                        ctl.finish = 1'b1;
                        state_next = trm_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = trm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* src/trm_datapath.sv */
module trm_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [63:0]         key,
    input  trm_pkg::dp_cmd_t    ctl,
    output trm_pkg::dp_status_t status,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    output logic                merged_valid,
    input  logic                merged_stall,
    output trm_pkg::out_t       merged_word
);

    localparam logic [trm_pkg::CNT_W-1:0] DEPTH = trm_pkg::CNT_W'(trm_pkg::RUN_DEPTH);
    localparam logic [trm_pkg::CNT_W-1:0] ONE   = trm_pkg::CNT_W'(1);

    logic [trm_pkg::KEY_W-1:0] first_run  [trm_pkg::RUN_DEPTH];
    logic [trm_pkg::KEY_W-1:0] second_run [trm_pkg::RUN_DEPTH];

    logic [trm_pkg::CNT_W-1:0] first_count_reg;
    logic [trm_pkg::CNT_W-1:0] second_count_reg;
    logic [trm_pkg::CNT_W-1:0] first_ptr_reg;
    logic [trm_pkg::CNT_W-1:0] second_ptr_reg;
    logic [trm_pkg::CNT_W-1:0] first_ptr_next;
    logic [trm_pkg::CNT_W-1:0] second_ptr_next;
    logic [trm_pkg::KEY_W-1:0] first_head_reg;
    logic [trm_pkg::KEY_W-1:0] second_head_reg;
    logic                      descending_reg;
    logic                      out_valid_reg;
    trm_pkg::out_t             out_word_reg;

    logic first_left;
    logic second_left;
    logic take_first;

    assign cfg_ready = 1'b1;

    assign first_left  = (first_ptr_reg < first_count_reg);
    assign second_left = (second_ptr_reg < second_count_reg);

    always_comb
    begin
        if (!first_left)
        begin
            take_first = 1'b0;
        end
        else if (!second_left)
        begin
            take_first = 1'b1;
        end
        else if (descending_reg)
        begin
            take_first = (first_head_reg > second_head_reg);
        end
        else
        begin
            take_first = !(first_head_reg > second_head_reg);
        end
    end

    always_comb
    begin
        first_ptr_next  = first_ptr_reg;
        second_ptr_next = second_ptr_reg;
        if (ctl.finish)
        begin
            first_ptr_next  = '0;
            second_ptr_next = '0;
        end
        else if (ctl.step)
        begin
            if (take_first)
            begin
                first_ptr_next = first_ptr_reg + ONE;
            end
            else
            begin
                second_ptr_next = second_ptr_reg + ONE;
            end
        end
    end

    assign status.runs_empty = (first_count_reg == '0) && (second_count_reg == '0);
    assign status.out_free   = !out_valid_reg || !merged_stall;
    assign status.step_last  = ((take_first ? first_ptr_reg + ONE : first_ptr_reg)
                                    == first_count_reg)
                            && ((take_first ? second_ptr_reg : second_ptr_reg + ONE)
                                    == second_count_reg);

    // run stores and head reads
    always_ff @(posedge clk)
    begin
        if (ctl.append_first && (first_count_reg != DEPTH))
        begin
            first_run[first_count_reg[trm_pkg::IDX_W-1:0]] <= key;
        end
        if (ctl.append_second && (second_count_reg != DEPTH))
        begin
            second_run[second_count_reg[trm_pkg::IDX_W-1:0]] <= key;
        end
        first_head_reg  <= first_run[first_ptr_next[trm_pkg::IDX_W-1:0]];
        second_head_reg <= second_run[second_ptr_next[trm_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            first_ptr_reg    <= '0;
            second_ptr_reg   <= '0;
            descending_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            first_ptr_reg  <= first_ptr_next;
            second_ptr_reg <= second_ptr_next;
            if (ctl.finish)
            begin
                first_count_reg  <= '0;
                second_count_reg <= '0;
            end
            else
            begin
                if (ctl.append_first && (first_count_reg != DEPTH))
                begin
                    first_count_reg <= first_count_reg + ONE;
                end
                if (ctl.append_second && (second_count_reg != DEPTH))
                begin
                    second_count_reg <= second_count_reg + ONE;
                end
            end
            if (cfg_valid)
            begin
                descending_reg <= cfg_data;
            end
            if (ctl.step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!merged_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            out_word_reg.out_key <= take_first ? first_head_reg : second_head_reg;
            out_word_reg.last    <= status.step_last;
        end
    end

    assign merged_valid = out_valid_reg;
    assign merged_word  = out_word_reg;

endmodule

/* src/two_run_merge.sv */
// Two-way merge of sorted runs of 64-bit unsigned keys. Command 0 appends key to
// the first run, 1 to the second run (a key for a full run of 32 is dropped), 2
// emits all held keys in merged order with last on the final word and then
// empties both runs; command 3 does nothing. A merge emits one word per cycle
// while the output is not stalled, paced by the registered head read of each
// run store; new words are not taken until the merge has handed its final word
// to the output register. Ascending order (descending = 0) takes the
// first run on ties; descending order takes the first run only when greater.
module two_run_merge (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          key_valid,
    output logic          key_stall,
    input  trm_pkg::in_t  key_word,
    output logic          merged_valid,
    input  logic          merged_stall,
    output trm_pkg::out_t merged_word,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);

    trm_pkg::dp_cmd_t    ctl;
    trm_pkg::dp_status_t status;

    trm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .cmd       (key_word.cmd),
        .status    (status),
        .ctl       (ctl)
    );

    trm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .key          (key_word.key),
        .ctl          (ctl),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .merged_valid (merged_valid),
        .merged_stall (merged_stall),
        .merged_word  (merged_word)
    );

endmodule
